>>> sv/bsp_point_leaf_locator_assert.svh
// Assertion macros shared by the point locator RTL.
`ifndef BSP_POINT_LEAF_LOCATOR_ASSERT_SVH
`define BSP_POINT_LEAF_LOCATOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BSPL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define BSPL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/bspl_pkg.sv
// Types, constants and item codes of the BSP point locator.
package bspl_pkg;

    localparam int NODE_COUNT  = 1024;
    localparam int PLANE_COUNT = 1024;
    localparam int LEAF_COUNT  = 1024;
    localparam int COORD_W     = 24;

    localparam int NODE_AW   = $clog2(NODE_COUNT);
    localparam int PLANE_AW  = $clog2(PLANE_COUNT);
    localparam int LEAF_W    = $clog2(LEAF_COUNT);
    localparam int CHILD_W   = 11;
    localparam int NORM_W    = 16;
    localparam int NORM_FRAC = 14;
    localparam int PROD_W    = NORM_W + COORD_W;
    // three products plus the scaled offset, exact
    localparam int DIST_W    = PROD_W + 2;

    localparam int S_DATA_W = 192;
    localparam int M_DATA_W = 16;

    // item kinds on the input tuser
    localparam logic [1:0] K_NODE   = 2'd0;
    localparam logic [1:0] K_PLANE  = 2'd1;
    localparam logic [1:0] K_LOCATE = 2'd2;

    typedef struct packed {
        logic signed [CHILD_W-1:0] back;
        logic signed [CHILD_W-1:0] front;
        logic [PLANE_AW-1:0]       plane;
    } t_node;

    typedef struct packed {
        logic signed [COORD_W-1:0] d;
        logic signed [NORM_W-1:0]  c;
        logic signed [NORM_W-1:0]  b;
        logic signed [NORM_W-1:0]  a;
    } t_plane;

    typedef struct packed {
        logic done;
        logic neg;
    } t_dist_res;

endpackage

>>> sv/bsp_point_leaf_locator.sv
// BSP point locator: table beats write one entry each; a locate beat walks the tree from node 0.
// Each tree level runs a node read, plane read, operand load and a multiply-accumulate
// on the single shared 16x24 multiplier of the distance unit.
// No new beat is taken while a locate walks or while its result waits for the output register.
// Reset (i_rst_n low, synchronous) clears the walk and output control only; the node and
// plane memories are not cleared and hold unknown data until written.
`include "bsp_point_leaf_locator_assert.svh"

module bsp_point_leaf_locator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // entry_index, node_plane, front_child, back_child, plane_a, plane_b, plane_c,
    // plane_d, point_x, point_y, point_z; zero fill above
    input  logic [bspl_pkg::S_DATA_W-1:0] i_s_tdata,
    // kind
    input  logic [1:0]                    i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // leaf_index; zero fill above
    output logic [bspl_pkg::M_DATA_W-1:0] o_m_tdata,
    // status
    output logic                          o_m_tuser
);
    import bspl_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_NODE  = 3'd1;
    localparam logic [2:0] S_PLANE = 3'd2;
    localparam logic [2:0] S_LOAD  = 3'd3;
    localparam logic [2:0] S_DIST  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]         r_state;
    logic [2:0]         n_state;
    logic [NODE_AW-1:0] r_node;
    logic [NODE_AW-1:0] n_node;
    logic [NODE_AW-1:0] r_visits;
    logic [NODE_AW-1:0] n_visits;
    logic [LEAF_W-1:0]  r_leaf;
    logic [LEAF_W-1:0]  n_leaf;
    logic               r_flag;
    logic               n_flag;
    logic               r_out_valid;
    logic               n_out_valid;
    logic [LEAF_W-1:0]  r_out_leaf;
    logic               r_out_flag;

    logic signed [COORD_W-1:0] r_x;
    logic signed [COORD_W-1:0] r_y;
    logic signed [COORD_W-1:0] r_z;

    logic                      s_fire;
    logic                      out_load;
    logic                      dist_start;
    logic signed [CHILD_W-1:0] child;
    t_node                     node_wdata;
    t_plane                    plane_wdata;
    t_node                     node_q;
    t_plane                    plane_q;
    t_dist_res                 dist_res;

    logic [NODE_AW-1:0]        f_entry;
    logic signed [COORD_W-1:0] f_x;
    logic signed [COORD_W-1:0] f_y;
    logic signed [COORD_W-1:0] f_z;

    assign f_entry = i_s_tdata[NODE_AW-1:0];
    assign f_x     = i_s_tdata[137:114];
    assign f_y     = i_s_tdata[161:138];
    assign f_z     = i_s_tdata[185:162];

    assign node_wdata.plane  = i_s_tdata[19:10];
    assign node_wdata.front  = i_s_tdata[30:20];
    assign node_wdata.back   = i_s_tdata[41:31];
    assign plane_wdata.a     = i_s_tdata[57:42];
    assign plane_wdata.b     = i_s_tdata[73:58];
    assign plane_wdata.c     = i_s_tdata[89:74];
    assign plane_wdata.d     = i_s_tdata[113:90];

    assign o_s_tready = (r_state == S_IDLE);
    assign s_fire     = i_s_tvalid & o_s_tready;

    bspl_tables u_tables (
        .i_clk         (i_clk),
        .i_node_we     (s_fire && (i_s_tuser == K_NODE)),
        .i_node_waddr  (f_entry),
        .i_node_wdata  (node_wdata),
        .i_node_raddr  (r_node),
        .o_node_q      (node_q),
        .i_plane_we    (s_fire && (i_s_tuser == K_PLANE)),
        .i_plane_waddr (i_s_tdata[PLANE_AW-1:0]),
        .i_plane_wdata (plane_wdata),
        .i_plane_raddr (node_q.plane),
        .o_plane_q     (plane_q)
    );

    bspl_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dist_start),
        .i_plane (plane_q),
        .i_x     (r_x),
        .i_y     (r_y),
        .i_z     (r_z),
        .o_res   (dist_res)
    );

    // node_q stays put for the whole level since r_node only moves on S_DIST exit
    assign child = dist_res.neg ? node_q.back : node_q.front;

    always_comb begin
        n_state    = r_state;
        n_node     = r_node;
        n_visits   = r_visits;
        n_leaf     = r_leaf;
        n_flag     = r_flag;
        dist_start = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (s_fire && (i_s_tuser == K_LOCATE)) begin
                    n_node   = '0;
                    n_visits = '0;
                    n_state  = S_NODE;
                end
            end
            S_NODE:  n_state = S_PLANE;
            S_PLANE: n_state = S_LOAD;
            S_LOAD: begin
                dist_start = 1'b1;
                n_state    = S_DIST;
            end
            S_DIST: begin
                if (dist_res.done) begin
                    if (child[CHILD_W-1]) begin
                        n_leaf  = ~child[LEAF_W-1:0];
                        n_flag  = 1'b0;
                        n_state = S_DONE;
                    end else if (($unsigned(child) >= CHILD_W'(NODE_COUNT)) ||
                                 (r_visits == NODE_AW'(NODE_COUNT - 1))) begin
                        // walk too long or child off the table
                        n_leaf  = '0;
                        n_flag  = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_node   = child[NODE_AW-1:0];
                        n_visits = r_visits + 1'b1;
                        n_state  = S_NODE;
                    end
                end
            end
            S_DONE: begin
                out_load = !r_out_valid || i_m_tready;
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node   <= n_node;
        r_visits <= n_visits;
        r_leaf   <= n_leaf;
        r_flag   <= n_flag;
        if (s_fire) begin
            r_x <= f_x;
            r_y <= f_y;
            r_z <= f_z;
        end
        if (out_load) begin
            r_out_leaf <= r_leaf;
            r_out_flag <= r_flag;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = M_DATA_W'(r_out_leaf);
    assign o_m_tuser  = r_out_flag;

    `BSPL_ASSERT_IMP(a_done_in_dist, dist_res.done, r_state == S_DIST, "distance done outside walk")
    `BSPL_ASSERT_NXT(a_locate_starts, s_fire && (i_s_tuser == K_LOCATE), r_state == S_NODE, "locate beat did not start a walk")
    `BSPL_ASSERT_NXT(a_flag_zero_leaf, out_load && r_flag, o_m_tvalid && o_m_tuser && (o_m_tdata == '0), "flagged result carries a leaf")
    `BSPL_ASSERT_IMP(a_load_needs_slot, out_load, !r_out_valid || i_m_tready, "result overwrote a pending beat")

endmodule

>>> sv/bspl_tables.sv
// Node and plane tables: one write port and one registered read port each.
module bspl_tables (
    input  logic                     i_clk,
    input  logic                     i_node_we,
    input  logic [bspl_pkg::NODE_AW-1:0]  i_node_waddr,
    input  bspl_pkg::t_node          i_node_wdata,
    input  logic [bspl_pkg::NODE_AW-1:0]  i_node_raddr,
    output bspl_pkg::t_node          o_node_q,
    input  logic                     i_plane_we,
    input  logic [bspl_pkg::PLANE_AW-1:0] i_plane_waddr,
    input  bspl_pkg::t_plane         i_plane_wdata,
    input  logic [bspl_pkg::PLANE_AW-1:0] i_plane_raddr,
    output bspl_pkg::t_plane         o_plane_q
);
    import bspl_pkg::*;

    t_node  node_mem  [NODE_COUNT];
    t_plane plane_mem [PLANE_COUNT];

    always_ff @(posedge i_clk) begin
        if (i_node_we) begin
            node_mem[i_node_waddr] <= i_node_wdata;
        end
        o_node_q <= node_mem[i_node_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_plane_we) begin
            plane_mem[i_plane_waddr] <= i_plane_wdata;
        end
        o_plane_q <= plane_mem[i_plane_raddr];
    end

endmodule

>>> sv/bspl_dist.sv
// Signed plane distance a*x+b*y+c*z-d*2^14 on one shared multiplier.
module bspl_dist (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  bspl_pkg::t_plane                 i_plane,
    input  logic signed [bspl_pkg::COORD_W-1:0] i_x,
    input  logic signed [bspl_pkg::COORD_W-1:0] i_y,
    input  logic signed [bspl_pkg::COORD_W-1:0] i_z,
    output bspl_pkg::t_dist_res              o_res
);
    import bspl_pkg::*;

    logic [1:0] r_step;
    logic [1:0] n_step;
    logic       r_done;
    logic       n_done;

    logic signed [NORM_W-1:0]  r_b;
    logic signed [NORM_W-1:0]  r_c;
    logic signed [COORD_W-1:0] r_y;
    logic signed [COORD_W-1:0] r_z;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [DIST_W-1:0]  r_acc;
    logic signed [DIST_W-1:0]  n_acc;
    logic signed [NORM_W-1:0]  mul_a;
    logic signed [COORD_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [DIST_W-1:0]  off_ext;

    always_comb begin
        mul_a = i_plane.a;
        mul_b = i_x;
        if (r_step == 2'd1) begin
            mul_a = r_b;
            mul_b = r_y;
        end else if (r_step == 2'd2) begin
            mul_a = r_c;
            mul_b = r_z;
        end
        mul_p = mul_a * mul_b;
    end

    assign off_ext = $signed({{(DIST_W - COORD_W){i_plane.d[COORD_W-1]}}, i_plane.d});

    always_comb begin
        n_step = r_step;
        n_done = 1'b0;
        n_acc  = r_acc + DIST_W'(r_prod);
        if (i_start) begin
            n_step = 2'd1;
            n_acc  = -(off_ext <<< NORM_FRAC);
        end else if (r_step == 2'd3) begin
            n_step = 2'd0;
            n_done = 1'b1;
        end else if (r_step != 2'd0) begin
            n_step = r_step + 2'd1;
        end else begin
            n_acc = r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_step <= n_step;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_b <= i_plane.b;
            r_c <= i_plane.c;
            r_y <= i_y;
            r_z <= i_z;
        end
        r_prod <= mul_p;
        r_acc  <= n_acc;
    end

    assign o_res.done = r_done;
    assign o_res.neg  = r_acc[DIST_W-1];

endmodule
